>>> rtl/core/sql_comment_stripper_defines.svh
// Assertion macros for the comment stripper RTL.
`ifndef SQL_COMMENT_STRIPPER_DEFINES_SVH
`define SQL_COMMENT_STRIPPER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SCS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/scs_pkg.sv
// Types, character codes and helpers for the SQL comment stripper.
package scs_pkg;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	typedef enum logic [2:0] {
		M_NORMAL = 3'd0,
		M_DASH   = 3'd1,
		M_SLASH  = 3'd2,
		M_LINE   = 3'd3,
		M_BLOCK  = 3'd4,
		M_BSTAR  = 3'd5,
		M_STRING = 3'd6,
		M_SQUOTE = 3'd7
	} mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_text;
	} out_t;

	// Up to two results produced by one input character.
	typedef struct packed {
		out_t       r0;
		out_t       r1;
		logic [1:0] cnt;
	} pair_t;

	function automatic pair_t put_char(pair_t p, logic [7:0] b);
		pair_t r;
		r = p;
		case (p.cnt)
			2'd0: begin
				r.r0 = '{out_byte: b, byte_valid: 1'b1, end_of_text: 1'b0};
				r.cnt = 2'd1;
			end
			2'd1: begin
				r.r1 = '{out_byte: b, byte_valid: 1'b1, end_of_text: 1'b0};
				r.cnt = 2'd2;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/sql_comment_stripper.sv
// Each accepted character that yields results is written into the registered result queue.
// Throughput: one character per cycle while item_stall is low; a character with two
// results sends them one at a time, absorbed by the two-entry result queue.
// item_stall is high only while the result queue is full.
// Reset (arst_n low, asynchronous): normal text mode, queue empty.
// Scan mode also returns to normal after every final character.
module sql_comment_stripper (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  scs_pkg::in_t   item,
	output logic           result_valid,
	input  logic           result_stall,
	output scs_pkg::out_t  result
);
	import scs_pkg::*;

	logic  accept;
	logic  push;
	logic  full;
	pair_t pair;

	assign item_stall = full;
	assign accept     = item_valid && !item_stall;
	assign push       = accept && (pair.cnt != 2'd0);

	scs_scanner u_scanner (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.pair   (pair)
	);

	scs_out_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.pair         (pair),
		.full         (full),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> rtl/core/scs_scanner.sv
// Scan state register and per-character decode into a result pair.
module scs_scanner (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  scs_pkg::in_t  item,
	output scs_pkg::pair_t pair
);
	import scs_pkg::*;

	mode_t      mode_q, mode_nx;
	logic       qd_q, qd_nx;
	logic       do_norm;
	logic [7:0] c;
	logic [7:0] qc;
	pair_t      pr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			qd_q   <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_nx;
			qd_q   <= qd_nx;
		end
	end

	always_comb begin
		pr      = '0;
		mode_nx = mode_q;
		qd_nx   = qd_q;
		do_norm = 1'b0;
		c       = item.in_byte;
		qc      = qd_q ? CH_DQUOTE : CH_SQUOTE;
		case (mode_q)
			M_NORMAL: do_norm = 1'b1;
			M_DASH: begin
				if (c == CH_DASH) begin
					mode_nx = M_LINE;
				end else begin
					pr      = put_char(pr, CH_DASH);
					do_norm = 1'b1;
				end
			end
			M_SLASH: begin
				if (c == CH_STAR) begin
					mode_nx = M_BLOCK;
				end else begin
					pr      = put_char(pr, CH_SLASH);
					do_norm = 1'b1;
				end
			end
			M_LINE: begin
				if (c == CH_NL) begin
					pr      = put_char(pr, c);
					mode_nx = M_NORMAL;
				end
			end
			M_BLOCK: begin
				if (c == CH_STAR)
					mode_nx = M_BSTAR;
			end
			M_BSTAR: begin
				if (c == CH_SLASH)
					mode_nx = M_NORMAL;
				else if (c != CH_STAR)
					mode_nx = M_BLOCK;
			end
			M_STRING: begin
				pr = put_char(pr, c);
				if (c == qc)
					mode_nx = M_SQUOTE;
			end
			M_SQUOTE: begin
				// doubled quote keeps the string open
				if (c == qc) begin
					pr      = put_char(pr, c);
					mode_nx = M_STRING;
				end else begin
					do_norm = 1'b1;
				end
			end
			default: do_norm = 1'b1;
		endcase

		if (do_norm) begin
			if (c == CH_DASH) begin
				mode_nx = M_DASH;
			end else if (c == CH_SLASH) begin
				mode_nx = M_SLASH;
			end else begin
				if (c == CH_SQUOTE || c == CH_DQUOTE) begin
					mode_nx = M_STRING;
					qd_nx   = (c == CH_DQUOTE);
				end else begin
					mode_nx = M_NORMAL;
				end
				pr = put_char(pr, c);
			end
		end

		if (item.in_last) begin
			// flush a held dash or slash, mark the last result as end of text, or emit a bare end marker if there is none
			if (mode_nx == M_DASH)
				pr = put_char(pr, CH_DASH);
			else if (mode_nx == M_SLASH)
				pr = put_char(pr, CH_SLASH);
			if (pr.cnt == 2'd0) begin
				pr.cnt = 2'd1;
				pr.r0  = '0;
			end
			if (pr.cnt == 2'd2)
				pr.r1.end_of_text = 1'b1;
			else
				pr.r0.end_of_text = 1'b1;
			mode_nx = M_NORMAL;
			qd_nx   = 1'b0;
		end
	end

	assign pair = pr;

endmodule

>>> rtl/core/scs_out_queue.sv
// Two-entry result queue; each entry holds one or two results, sent one at a time.
`include "sql_comment_stripper_defines.svh"

module scs_out_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  scs_pkg::pair_t pair,
	output logic           full,
	output logic           result_valid,
	input  logic           result_stall,
	output scs_pkg::out_t  result
);
	import scs_pkg::*;

	pair_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       sub_q;
	logic       take;
	logic       pop;
	pair_t      head;

	assign head         = mem_q[rd_ptr_q];
	assign result_valid = (count_q != 2'd0);
	assign result       = sub_q ? head.r1 : head.r0;
	assign full         = (count_q == 2'd2);
	assign take         = result_valid && !result_stall;
	assign pop          = take && (sub_q || head.cnt != 2'd2);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= pair;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			sub_q    <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (take)
				sub_q <= !pop;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`SCS_ASSERT_NOW(a_count_max, 1'b1, count_q != 2'd3, "queue count out of range")
	`SCS_ASSERT_NOW(a_no_push_full, push, !full, "push into full result queue")
	`SCS_ASSERT_NOW(a_sub_two, sub_q, count_q != 2'd0 && head.cnt == 2'd2,
		"second result selected from an entry without one")
	`SCS_ASSERT_NEXT(a_pop_clears_sub, pop, !sub_q, "sub index not reset after pop")

endmodule

>>> tb/strip_checker.sv
// Checker for the SQL comment stripper: predicts the kept text and compares every result.
`timescale 1ns / 100ps

module strip_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          item_stall,
	input  scs_pkg::in_t  item,
	input  logic          result_valid,
	input  logic          result_stall,
	input  scs_pkg::out_t result,
	output int            fails,
	output int            pending
);
	import scs_pkg::*;

	mode_t scan;
	logic  quote_dbl;
	out_t  kept_q[$];
	out_t  step_q[$];
	int    fail_cnt;

	function automatic void keep_char(logic [7:0] b);
		out_t r;
		r = '{out_byte: b, byte_valid: 1'b1, end_of_text: 1'b0};
		step_q = {step_q, r};
	endfunction

	// Plain text handling, also used when a held character or closed string falls back.
	function automatic void plain_char(logic [7:0] c);
		if (c == CH_DASH) begin
			scan = M_DASH;
		end else if (c == CH_SLASH) begin
			scan = M_SLASH;
		end else begin
			if (c == CH_SQUOTE || c == CH_DQUOTE) begin
				scan = M_STRING;
				quote_dbl = (c == CH_DQUOTE);
			end else begin
				scan = M_NORMAL;
			end
			keep_char(c);
		end
	endfunction

	function automatic void strip_char(in_t x);
		logic [7:0] c;
		logic [7:0] qc;
		out_t       r;
		c = x.in_byte;
		qc = quote_dbl ? CH_DQUOTE : CH_SQUOTE;
		step_q.delete();
		case (scan)
			M_NORMAL: plain_char(c);
			M_DASH: begin
				if (c == CH_DASH) begin
					scan = M_LINE;
				end else begin
					keep_char(CH_DASH);
					plain_char(c);
				end
			end
			M_SLASH: begin
				if (c == CH_STAR) begin
					scan = M_BLOCK;
				end else begin
					keep_char(CH_SLASH);
					plain_char(c);
				end
			end
			M_LINE: begin
				if (c == CH_NL) begin
					keep_char(c);
					scan = M_NORMAL;
				end
			end
			M_BLOCK: begin
				if (c == CH_STAR)
					scan = M_BSTAR;
			end
			M_BSTAR: begin
				if (c == CH_SLASH)
					scan = M_NORMAL;
				else if (c != CH_STAR)
					scan = M_BLOCK;
			end
			M_STRING: begin
				keep_char(c);
				if (c == qc)
					scan = M_SQUOTE;
			end
			default: begin
				// doubled quote reopens the string
				if (c == qc) begin
					keep_char(c);
					scan = M_STRING;
				end else begin
					plain_char(c);
				end
			end
		endcase
		if (x.in_last) begin
			if (scan == M_DASH)
				keep_char(CH_DASH);
			else if (scan == M_SLASH)
				keep_char(CH_SLASH);
			if (step_q.size() == 0)
				r = '0;
			else
				r = step_q.pop_back();
			r.end_of_text = 1'b1;
			step_q = {step_q, r};
			scan = M_NORMAL;
			quote_dbl = 1'b0;
		end
		kept_q = {kept_q, step_q};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			scan = M_NORMAL;
			quote_dbl = 1'b0;
			kept_q.delete();
			fail_cnt = 0;
			fails <= 0;
			pending <= 0;
		end else begin
			// results at this edge belong to older transactions, so check before predicting
			if (result_valid && !result_stall) begin
				if (kept_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("unexpected result: byte %02h valid %b end %b",
							result.out_byte, result.byte_valid, result.end_of_text);
				end else begin
					want = kept_q.pop_front();
					if (result.out_byte !== want.out_byte ||
						result.byte_valid !== want.byte_valid ||
						result.end_of_text !== want.end_of_text) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("mismatch: exp %02h/%b/%b got %02h/%b/%b",
								want.out_byte, want.byte_valid, want.end_of_text,
								result.out_byte, result.byte_valid,
								result.end_of_text);
					end
				end
			end
			if (item_valid && !item_stall)
				strip_char(item);
			fails <= fail_cnt;
			pending <= kept_q.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// Top of the SQL comment stripper testbench: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_top;
	import scs_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int TEXT_ITEMS   = 1450;

	logic clk          = 1'b0;
	logic arst_n       = 1'b0;
	logic item_valid   = 1'b0;
	logic item_stall;
	in_t  item         = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_t result;
	int   fails;
	int   pending;

	logic [7:0] text_q[$];
	int         sent      = 0;
	bit         calm      = 1'b0;
	bit         hold_req  = 1'b0;
	bit         hold_done = 1'b0;

	always #10 clk = ~clk;

	sql_comment_stripper u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	strip_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.fails        (fails),
		.pending      (pending)
	);

	function automatic void add_byte(logic [7:0] b);
		text_q = {text_q, b};
	endfunction

	task automatic send_char(logic [7:0] b, logic last);
		// idle cycle by cycle, about 31 in a hundred
		while (!calm && $urandom_range(99) < 31) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= in_t'{b, last};
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_char(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	task automatic queue_str(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	// sender stops and waits for every outstanding result
	task automatic drain();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	function automatic logic [7:0] rand_char();
		case ($urandom_range(11))
			0: return CH_DASH;
			1: return CH_SLASH;
			2: return CH_STAR;
			3: return CH_NL;
			4: return CH_SQUOTE;
			5: return CH_DQUOTE;
			6, 7, 8: return 8'h61 + 8'($urandom_range(25));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic void add_piece();
		logic [7:0] q;
		int         n;
		n = $urandom_range(5);
		case ($urandom_range(9))
			0, 1: begin
				for (int i = 0; i <= n; i++)
					add_byte(8'h61 + 8'($urandom_range(25)));
			end
			2, 3: begin
				add_byte(CH_DASH);
				add_byte(CH_DASH);
				for (int i = 0; i < n; i++)
					add_byte(rand_char());
				add_byte(CH_NL);
			end
			4, 5: begin
				add_byte(CH_SLASH);
				add_byte(CH_STAR);
				for (int i = 0; i < n; i++)
					add_byte(rand_char());
				add_byte(CH_STAR);
				add_byte(CH_SLASH);
			end
			6, 7: begin
				q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
				add_byte(q);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(4) == 0)
						add_byte(q);
					add_byte(rand_char());
				end
				add_byte(q);
			end
			default: add_byte(rand_char());
		endcase
	endfunction

	// receiver: random stalls, one long hold-off, and a calm stretch
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				result_stall <= 1'b1;
				repeat (80) @(posedge clk);
				hold_done = 1'b1;
			end
			result_stall <= calm ? 1'b0 : ($urandom_range(99) < 31);
		end
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		bit paused;
		paused = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// held dash / slash flushed at the final byte
		queue_str("-");
		send_text();
		queue_str("/");
		send_text();
		// line comment keeps its newline, then a trailing dash
		queue_str("a--c\n-");
		send_text();
		// doubled quote escape, closing quote as final byte
		queue_str("'a''b'");
		send_text();
		// block comment ending the text gives a bare end marker
		queue_str("/**/");
		send_text();
		// unterminated string, then unterminated line comment
		queue_str("\"x");
		send_text();
		queue_str("--x");
		send_text();
		add_byte(8'h00);
		add_byte(8'hFF);
		send_text();
		drain();

		while (sent < TEXT_ITEMS) begin
			calm = (sent >= 500 && sent < 750);
			if (sent >= 300)
				hold_req = 1'b1;
			if (!paused && sent >= 1000) begin
				drain();
				paused = 1'b1;
			end
			if ($urandom_range(9) == 0) begin
				add_byte(rand_char());
			end else begin
				repeat ($urandom_range(6, 1))
					add_piece();
			end
			send_text();
		end
		calm = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
